// File: hdl/binomial_mod_prime_lucas_defines.svh
// Assertion helpers shared by the binomial residue block.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef BINOMIAL_MOD_PRIME_LUCAS_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_LUCAS_DEFINES_SVH

// Same-cycle implication.
`define BMPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bmpl_pkg.sv
package bmpl_pkg;

  localparam int VALUE_BITS_DEF = 40;
  localparam int MOD_MAX_DEF    = 31;
  localparam int MOD_RESET      = 2;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;

  // Register indexes (byte address is 4 * index)
  localparam logic REG_MODULUS = 1'b0;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIGIT,
    OP_DIRECT,
    OP_ROW_INIT,
    OP_ROW_STEP,
    OP_SHIFT_INIT,
    OP_SHIFT_STEP,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_ACC_UPD,
    OP_ACC_ZERO,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_MOD_BAD,
    COND_N_LT_K,
    COND_N_EQ_K,
    COND_N_LE_M,
    COND_DN_LT_DK,
    COND_CNT_NZ
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic mod_bad;
    logic n_lt_k;
    logic n_eq_k;
    logic n_le_m;
    logic dn_lt_dk;
    logic cnt_nz;
  } stat_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Program step addresses
  localparam pc_t STEP_INIT       = 5'd0;
  localparam pc_t STEP_TEST_LT    = 5'd1;
  localparam pc_t STEP_TEST_EQ    = 5'd2;
  localparam pc_t STEP_TEST_SMALL = 5'd3;
  localparam pc_t STEP_DIV_START  = 5'd4;
  localparam pc_t STEP_DIV_LOOP   = 5'd5;
  localparam pc_t STEP_DIGIT      = 5'd6;
  localparam pc_t STEP_ROW_INIT   = 5'd7;
  localparam pc_t STEP_ROW_LOOP   = 5'd8;
  localparam pc_t STEP_SHIFT_INIT = 5'd9;
  localparam pc_t STEP_SHIFT_LOOP = 5'd10;
  localparam pc_t STEP_MUL_INIT   = 5'd11;
  localparam pc_t STEP_MUL_LOOP   = 5'd12;
  localparam pc_t STEP_ACC_UPD    = 5'd13;
  localparam pc_t STEP_DIRECT     = 5'd14;
  localparam pc_t STEP_ZERO       = 5'd15;
  localparam pc_t STEP_EMIT       = 5'd16;

  function automatic ctrl_t ucode_rom(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_NEVER, target: STEP_INIT};
    case (pc)
      STEP_INIT:       w = '{op: OP_INIT,       cond: COND_MOD_BAD,  target: STEP_ZERO};
      STEP_TEST_LT:    w = '{op: OP_NOP,        cond: COND_N_LT_K,   target: STEP_ZERO};
      STEP_TEST_EQ:    w = '{op: OP_NOP,        cond: COND_N_EQ_K,   target: STEP_EMIT};
      STEP_TEST_SMALL: w = '{op: OP_NOP,        cond: COND_N_LE_M,   target: STEP_DIRECT};
      STEP_DIV_START:  w = '{op: OP_DIV_START,  cond: COND_NEVER,    target: STEP_INIT};
      STEP_DIV_LOOP:   w = '{op: OP_DIV_STEP,   cond: COND_CNT_NZ,   target: STEP_DIV_LOOP};
      STEP_DIGIT:      w = '{op: OP_DIGIT,      cond: COND_DN_LT_DK, target: STEP_ZERO};
      STEP_ROW_INIT:   w = '{op: OP_ROW_INIT,   cond: COND_NEVER,    target: STEP_INIT};
      STEP_ROW_LOOP:   w = '{op: OP_ROW_STEP,   cond: COND_CNT_NZ,   target: STEP_ROW_LOOP};
      STEP_SHIFT_INIT: w = '{op: OP_SHIFT_INIT, cond: COND_NEVER,    target: STEP_INIT};
      STEP_SHIFT_LOOP: w = '{op: OP_SHIFT_STEP, cond: COND_CNT_NZ,   target: STEP_SHIFT_LOOP};
      STEP_MUL_INIT:   w = '{op: OP_MUL_INIT,   cond: COND_NEVER,    target: STEP_INIT};
      STEP_MUL_LOOP:   w = '{op: OP_MUL_STEP,   cond: COND_CNT_NZ,   target: STEP_MUL_LOOP};
      STEP_ACC_UPD:    w = '{op: OP_ACC_UPD,    cond: COND_ALWAYS,   target: STEP_TEST_LT};
      STEP_DIRECT:     w = '{op: OP_DIRECT,     cond: COND_ALWAYS,   target: STEP_ROW_INIT};
      STEP_ZERO:       w = '{op: OP_ACC_ZERO,   cond: COND_ALWAYS,   target: STEP_EMIT};
      STEP_EMIT:       w = '{op: OP_EMIT,       cond: COND_NEVER,    target: STEP_INIT};
      default:         w = '{op: OP_NOP,        cond: COND_NEVER,    target: STEP_INIT};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/binomial_mod_prime_lucas.sv
// Binomial coefficient C(n,k) modulo a small prime p, by Lucas's theorem.
// Input channel: in_valid/in_stall carry n (in_upper_value) and k (in_lower_value).
// The block takes one transaction at a time; in_stall stays high while it works.
// Result channel: out_valid/out_stall carry the residue. It sits in an output
// register, so the next transaction is taken while a result waits there.
// The modulus register sits at byte address 0 of the APB port; write it only
// while the block is idle. Moduli below 2 give a residue of 0.
// Operation: a microcoded sequencer steps a shared datapath. Each base-p digit
// takes a bit-serial divide of n and k, a Pascal row walk up to row dn, a
// shift down by dk and a bit-serial modular multiply; further steps start and
// finish the item.
// Reset: sequencer idle, output empty, modulus 2.
// A stalled receiver holds the result; the sequencer then waits on its last
// step and takes no new transaction until the result register frees up.
`include "binomial_mod_prime_lucas_defines.svh"

module binomial_mod_prime_lucas #(
  parameter int VALUE_BITS = bmpl_pkg::VALUE_BITS_DEF,
  parameter int MOD_MAX    = bmpl_pkg::MOD_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VALUE_BITS-1:0]         in_upper_value,
  input  logic [VALUE_BITS-1:0]         in_lower_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [$clog2(MOD_MAX+1)-1:0]  out_residue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmpl_pkg::APB_AW-1:0]   paddr,
  input  logic [bmpl_pkg::APB_DW-1:0]   pwdata,
  output logic [bmpl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import bmpl_pkg::*;

  localparam int RES_W = $clog2(MOD_MAX + 1);

  logic [RES_W-1:0] mod_r;
  logic [RES_W-1:0] mod_eff;
  logic             out_valid_r;
  logic [RES_W-1:0] out_residue_r;
  logic             busy, emit, out_free, in_accept;
  logic             reg_sel;
  ctrl_t            ctrl;
  stat_t            stat;
  logic [RES_W-1:0] acc;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_MODULUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= RES_W'(MOD_RESET);
    end else if (psel && penable && pwrite && reg_sel) begin
      mod_r <= pwdata[RES_W-1:0];
    end
  end

  assign prdata  = reg_sel ? APB_DW'(mod_r) : '0;
  assign mod_eff = (mod_r > RES_W'(MOD_MAX)) ? RES_W'(MOD_MAX) : mod_r;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;

  bmpl_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (in_accept),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .emit_o     (emit),
    .busy_o     (busy)
  );

  bmpl_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MOD_MAX    (MOD_MAX)
  ) u_dp (
    .clk     (clk),
    .ctrl_i  (ctrl),
    .load_i  (in_accept),
    .upper_i (in_upper_value),
    .lower_i (in_lower_value),
    .mod_i   (mod_eff),
    .stat_o  (stat),
    .acc_o   (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_residue_r <= acc;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

  `BMPL_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while block still idle")
  `BMPL_ASSERT_NXT(a_emit_fills_output, emit, out_valid, "emitted result not registered")
  `BMPL_ASSERT_NXT(a_stall_holds_result, out_valid && out_stall, out_valid && $stable(out_residue), "stalled result changed")

endmodule

// File: hdl/bmpl_seq.sv
`include "binomial_mod_prime_lucas_defines.svh"

module bmpl_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start_i,
  input  logic            out_free_i,
  input  bmpl_pkg::stat_t stat_i,
  output bmpl_pkg::ctrl_t ctrl_o,
  output logic            emit_o,
  output logic            busy_o
);
  import bmpl_pkg::*;

  seq_state_t state_r, state_nxt;
  pc_t        pc_r, pc_nxt;
  ctrl_t      word;
  logic       taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= STEP_INIT;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_comb begin
    word = ucode_rom(pc_r);
    case (word.cond)
      COND_NEVER:    taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_MOD_BAD:  taken = stat_i.mod_bad;
      COND_N_LT_K:   taken = stat_i.n_lt_k;
      COND_N_EQ_K:   taken = stat_i.n_eq_k;
      COND_N_LE_M:   taken = stat_i.n_le_m;
      COND_DN_LT_DK: taken = stat_i.dn_lt_dk;
      COND_CNT_NZ:   taken = stat_i.cnt_nz;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ctrl_o    = '{op: OP_NOP, cond: COND_NEVER, target: STEP_INIT};
    emit_o    = 1'b0;
    busy_o    = 1'b1;
    case (state_r)
      SEQ_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = STEP_INIT;
        end
      end
      SEQ_RUN: begin
        ctrl_o = word;
        if (word.op == OP_EMIT) begin
          // hold on the emit step until the output register frees up
          if (out_free_i) begin
            emit_o    = 1'b1;
            state_nxt = SEQ_IDLE;
          end
        end else begin
          pc_nxt = taken ? word.target : pc_r + 1'b1;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  `BMPL_ASSERT_IMP(a_emit_needs_slot, emit_o, out_free_i && state_r == SEQ_RUN, "emit without free output slot")
  `BMPL_ASSERT_NXT(a_start_at_init, start_i && state_r == SEQ_IDLE, state_r == SEQ_RUN && pc_r == STEP_INIT, "program did not start at step zero")
  `BMPL_ASSERT_IMP(a_pc_in_program, state_r == SEQ_RUN, pc_r <= STEP_EMIT, "step counter ran past the program")

endmodule

// File: hdl/bmpl_dp.sv
module bmpl_dp #(
  parameter int VALUE_BITS = bmpl_pkg::VALUE_BITS_DEF,
  parameter int MOD_MAX    = bmpl_pkg::MOD_MAX_DEF
) (
  input  logic                         clk,
  input  bmpl_pkg::ctrl_t              ctrl_i,
  input  logic                         load_i,
  input  logic [VALUE_BITS-1:0]        upper_i,
  input  logic [VALUE_BITS-1:0]        lower_i,
  input  logic [$clog2(MOD_MAX+1)-1:0] mod_i,
  output bmpl_pkg::stat_t              stat_o,
  output logic [$clog2(MOD_MAX+1)-1:0] acc_o
);
  import bmpl_pkg::*;

  localparam int RES_W   = $clog2(MOD_MAX + 1);
  localparam int CNT_MAX = (VALUE_BITS > MOD_MAX) ? VALUE_BITS : MOD_MAX;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  logic [VALUE_BITS-1:0] n_r, k_r;
  logic [RES_W-1:0]      rem_n_r, rem_k_r;
  logic [RES_W-1:0]      a_r, b_r;
  logic [RES_W-1:0]      acc_r, prod_r, mul_b_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [RES_W-1:0]      row_r [0:MOD_MAX];

  logic [RES_W-1:0]      row_nxt [0:MOD_MAX];
  logic [RES_W:0]        t_n, t_k;
  logic                  q_n, q_k;
  logic [RES_W-1:0]      rem_n_nxt, rem_k_nxt;
  logic [RES_W:0]        dbl, add_s;
  logic [RES_W-1:0]      dbl_m, prod_nxt;
  logic [RES_W:0]        m_ext;
  logic                  cnt_nz;

  assign m_ext  = {1'b0, mod_i};
  assign cnt_nz = (cnt_r != '0);

  // One restoring-division bit for each of n and k, shared divisor
  always_comb begin
    t_n       = {rem_n_r, n_r[VALUE_BITS-1]};
    t_k       = {rem_k_r, k_r[VALUE_BITS-1]};
    q_n       = (t_n >= m_ext);
    q_k       = (t_k >= m_ext);
    rem_n_nxt = q_n ? RES_W'(t_n - m_ext) : RES_W'(t_n);
    rem_k_nxt = q_k ? RES_W'(t_k - m_ext) : RES_W'(t_k);
  end

  // Pascal row advance: every cell but cell zero adds its left neighbor, mod m
  always_comb begin
    logic [RES_W:0] s;
    s = '0;
    row_nxt[0] = row_r[0];
    for (int j = 1; j <= MOD_MAX; j++) begin
      s          = {1'b0, row_r[j]} + {1'b0, row_r[j-1]};
      row_nxt[j] = (s >= m_ext) ? RES_W'(s - m_ext) : RES_W'(s);
    end
  end

  // Shift-and-add modular multiply, multiplier MSB first
  always_comb begin
    dbl      = {prod_r, 1'b0};
    dbl_m    = (dbl >= m_ext) ? RES_W'(dbl - m_ext) : RES_W'(dbl);
    add_s    = {1'b0, dbl_m} + (mul_b_r[RES_W-1] ? {1'b0, acc_r} : '0);
    prod_nxt = (add_s >= m_ext) ? RES_W'(add_s - m_ext) : RES_W'(add_s);
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      n_r <= upper_i;
      k_r <= lower_i;
    end
    case (ctrl_i.op)
      OP_INIT: begin
        acc_r <= RES_W'(1);
      end
      OP_DIV_START: begin
        rem_n_r <= '0;
        rem_k_r <= '0;
        cnt_r   <= CNT_W'(VALUE_BITS);
      end
      OP_DIV_STEP: begin
        if (cnt_nz) begin
          n_r     <= {n_r[VALUE_BITS-2:0], q_n};
          k_r     <= {k_r[VALUE_BITS-2:0], q_k};
          rem_n_r <= rem_n_nxt;
          rem_k_r <= rem_k_nxt;
          cnt_r   <= cnt_r - 1'b1;
        end
      end
      OP_DIGIT: begin
        a_r <= rem_n_r;
        b_r <= rem_k_r;
      end
      OP_DIRECT: begin
        // n is at most m: take it whole and leave n = k = 0 to finish
        a_r <= n_r[RES_W-1:0];
        b_r <= k_r[RES_W-1:0];
        n_r <= '0;
        k_r <= '0;
      end
      OP_ROW_INIT: begin
        for (int j = 0; j <= MOD_MAX; j++) begin
          row_r[j] <= (j == 0) ? RES_W'(1) : '0;
        end
        cnt_r <= CNT_W'(a_r);
      end
      OP_ROW_STEP: begin
        if (cnt_nz) begin
          for (int j = 0; j <= MOD_MAX; j++) begin
            row_r[j] <= row_nxt[j];
          end
          cnt_r <= cnt_r - 1'b1;
        end
      end
      OP_SHIFT_INIT: begin
        cnt_r <= CNT_W'(b_r);
      end
      OP_SHIFT_STEP: begin
        // walk the wanted entry down to cell zero
        if (cnt_nz) begin
          for (int j = 0; j < MOD_MAX; j++) begin
            row_r[j] <= row_r[j+1];
          end
          row_r[MOD_MAX] <= '0;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      OP_MUL_INIT: begin
        mul_b_r <= row_r[0];
        prod_r  <= '0;
        cnt_r   <= CNT_W'(RES_W);
      end
      OP_MUL_STEP: begin
        if (cnt_nz) begin
          prod_r  <= prod_nxt;
          mul_b_r <= {mul_b_r[RES_W-2:0], 1'b0};
          cnt_r   <= cnt_r - 1'b1;
        end
      end
      OP_ACC_UPD: begin
        acc_r <= prod_r;
      end
      OP_ACC_ZERO: begin
        acc_r <= '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.mod_bad  = (mod_i < RES_W'(2));
    stat_o.n_lt_k   = (n_r < k_r);
    stat_o.n_eq_k   = (n_r == k_r);
    stat_o.n_le_m   = (n_r <= VALUE_BITS'(mod_i));
    stat_o.dn_lt_dk = (rem_n_r < rem_k_r);
    stat_o.cnt_nz   = cnt_nz;
  end

  assign acc_o = acc_r;

endmodule

// File: dv/tb_binomial_mod_prime_lucas.sv
`timescale 1ns / 1ps

module tb_binomial_mod_prime_lucas;
  import bmpl_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int RW = $clog2(MOD_MAX_DEF + 1);
  localparam int REG_SPARE = 1;
  localparam logic [APB_AW-1:0] MODULUS_ADDR = APB_AW'(4 * REG_MODULUS);
  localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(4 * REG_SPARE);
  localparam bit [VB-1:0] ALL_ONES = '1;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 108;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 3000;
  localparam longint LIMIT = 20_000_000;

  // Expected residues, in acceptance order, plus a private copy of the modulus.
  class residue_board;
    logic [RW-1:0] residues_due[$];
    bit [RW-1:0] modulus;
    int failures;

    function new();
      modulus = RW'(MOD_RESET);
      failures = 0;
    endfunction

    function void write_register(int unsigned index, logic [APB_DW-1:0] data);
      if (index == REG_MODULUS) modulus = data[RW-1:0];
    endfunction

    // C(a,b) mod m from one Pascal row built up to row a.
    function longint unsigned pascal_entry(longint unsigned a, longint unsigned b,
                                           longint unsigned m);
      longint unsigned row[MOD_MAX_DEF+1];
      int unsigned i, j;
      if (a > MOD_MAX_DEF || b > a) return 0;
      foreach (row[x]) row[x] = 0;
      row[0] = 1 % m;
      for (i = 1; i <= a; i++)
        for (j = i; j >= 1; j--) row[j] = (row[j] + row[j-1]) % m;
      return row[b];
    endfunction

    function logic [RW-1:0] lucas_residue(longint unsigned n, longint unsigned k);
      longint unsigned m, acc, dn, dk, res;
      bit live;
      m = modulus;
      if (m > MOD_MAX_DEF) m = MOD_MAX_DEF;
      if (m < 2) return '0;
      acc = 1 % m;
      res = 0;
      live = 1'b1;
      while (live) begin
        if (n < k) begin
          res = 0;
          live = 1'b0;
        end else if (n == k) begin
          res = acc;
          live = 1'b0;
        end else if (n <= m) begin
          res = (acc * pascal_entry(n, k, m)) % m;
          live = 1'b0;
        end else begin
          dn = n % m;
          dk = k % m;
          if (dn < dk) begin
            res = 0;
            live = 1'b0;
          end else begin
            acc = (acc * pascal_entry(dn, dk, m)) % m;
            n = n / m;
            k = k / m;
          end
        end
      end
      return res[RW-1:0];
    endfunction

    function void note_operands(bit [VB-1:0] n, bit [VB-1:0] k);
      residues_due = {residues_due, lucas_residue(n, k)};
    endfunction

    function void check_residue(logic [RW-1:0] got);
      logic [RW-1:0] want;
      if (residues_due.size() == 0) begin
        $error("out_residue: no transaction expected, actual %0d", got);
        failures++;
      end else begin
        want = residues_due.pop_front();
        if (got !== want) begin
          $error("out_residue: expected %0d, actual %0d", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VB-1:0] in_upper_value = '0;
  logic [VB-1:0] in_lower_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RW-1:0] out_residue;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  residue_board board;
  int sender_idle_pct = 23;
  int receiver_idle_pct = 76;
  int hold_left = 0;
  longint cycle_count = 0;

  binomial_mod_prime_lucas DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_upper_value(in_upper_value),
    .in_lower_value(in_lower_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_residue(out_residue),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: a requested hold-off wins over the random stall.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_residue(out_residue);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("binomial_mod_prime_lucas test failed");
      $finish;
    end
  end

  task automatic offer_operands(input bit [VB-1:0] n, input bit [VB-1:0] k);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_upper_value = n;
    in_lower_value = k;
    do @(posedge clk); while (in_stall);
    board.note_operands(n, k);
  endtask

  // Drop valid and wait for every outstanding residue.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.residues_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.write_register(addr >> 2, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read_modulus();
    logic [APB_DW-1:0] want;
    want = APB_DW'(board.modulus);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = MODULUS_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata: expected %0d, actual %0d", want, prdata);
      board.failures++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Mostly short operands, now and then full width or all ones.
  function automatic bit [VB-1:0] operand_draw();
    bit [63:0] raw;
    int unsigned len;
    raw = {$urandom, $urandom};
    if ($urandom_range(19) == 0) return ALL_ONES;
    len = ($urandom_range(9) < 7) ? $urandom_range(16, 1) : $urandom_range(VB, 1);
    return raw[VB-1:0] & ((VB'(1) << len) - VB'(1));
  endfunction

  // Pick k digit by digit in base m so no digit exceeds n's: walks every digit.
  function automatic bit [VB-1:0] lower_within(bit [VB-1:0] n, int unsigned m);
    longint unsigned t, place, k;
    int unsigned d;
    t = n;
    place = 1;
    k = 0;
    while (t != 0) begin
      d = t % m;
      k += longint'($urandom_range(d, 0)) * place;
      place *= m;
      t /= m;
    end
    return k[VB-1:0];
  endfunction

  initial begin
    int phase_mods[PHASES];
    logic [APB_DW-1:0] data;
    bit [VB-1:0] n, k, swap;
    int kind;
    int m;

    phase_mods = '{2, 3, 5, 7, 31, 0, 1, 4, 9, 11, 13, 17, 19, 23, 29, 30};
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset modulus of two, then directed corners at the widest prime.
    apb_read_modulus();
    offer_operands(VB'(10), VB'(4));
    offer_operands(ALL_ONES, VB'(40'h55_5555_5555));
    drain_results();
    apb_write(MODULUS_ADDR, APB_DW'(31));
    apb_read_modulus();
    offer_operands(VB'(0), VB'(0));
    offer_operands(ALL_ONES, ALL_ONES);
    offer_operands(ALL_ONES, VB'(0));
    offer_operands(VB'(0), ALL_ONES);
    offer_operands(VB'(5), VB'(7));
    offer_operands(VB'(31), VB'(15));
    offer_operands(VB'(30), VB'(29));
    offer_operands(VB'(32), VB'(1));
    offer_operands(VB'(62), VB'(3));
    offer_operands(ALL_ONES, VB'(12345));
    offer_operands(ALL_ONES, ALL_ONES - VB'(1));
    drain_results();
    // Degenerate moduli force a zero residue, even for n equal to k.
    apb_write(MODULUS_ADDR, APB_DW'(0));
    offer_operands(VB'(100), VB'(3));
    offer_operands(ALL_ONES, ALL_ONES);
    drain_results();
    apb_write(MODULUS_ADDR, APB_DW'(1));
    offer_operands(VB'(7), VB'(7));
    offer_operands(VB'(0), VB'(0));
    drain_results();
    // Composite modulus still runs the digit walk.
    apb_write(MODULUS_ADDR, APB_DW'(4));
    offer_operands(VB'(4), VB'(2));
    offer_operands(VB'(6), VB'(2));
    offer_operands(VB'(10), VB'(3));
    offer_operands(ALL_ONES, VB'(5));
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = (p < 6) ? 23 : (p < 11) ? 76 : 0;
      receiver_idle_pct = (p < 6) ? 76 : (p < 11) ? 23 : 0;
      data = $urandom;
      if ($urandom_range(3) != 0) data = '0;
      data[RW-1:0] = RW'(phase_mods[p]);
      apb_write(MODULUS_ADDR, data);
      if (p == 7) apb_write(SPARE_ADDR, $urandom);
      apb_read_modulus();
      m = board.modulus;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 2 || p == 12) && i == PHASE_ITEMS / 3) hold_left = HOLD_CYCLES;
        kind = $urandom_range(99);
        n = operand_draw();
        if (kind < 60 && m >= 2) begin
          k = lower_within(n, m);
        end else if (kind < 68) begin
          k = n;
        end else if (kind < 84) begin
          k = operand_draw();
          if (k < n) begin
            swap = n;
            n = k;
            k = swap;
          end
        end else begin
          k = operand_draw();
        end
        offer_operands(n, k);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.residues_due.size() == 0)
      $display("binomial_mod_prime_lucas test passed");
    else
      $display("binomial_mod_prime_lucas test failed");
    $finish;
  end

endmodule
